// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define IPV4M_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define IPV4M_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ipv4m_pkg.sv
package ipv4m_pkg;

   localparam int KEY_WIDTH       = 32;
   localparam int ENTRY_WIDTH     = KEY_WIDTH + 1;
   localparam int BUCKETS_DEFAULT = 4096;
   localparam int WAYS_DEFAULT    = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [KEY_WIDTH-1:0] HASH_INIT = 32'hdeadbeef;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_SIDE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_INVERT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HASH_SEED    = 2'd2;

   typedef enum logic [1:0] {
      MODE_MATCH  = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_FLUSH  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [KEY_WIDTH-1:0] source_address;
      logic [KEY_WIDTH-1:0] dest_address;
   } req_type;

   typedef struct packed {
      logic hit;
      logic status;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [KEY_WIDTH-1:0] addr;
   } entry_type;

   function automatic logic [KEY_WIDTH-1:0] rotl32(input logic [KEY_WIDTH-1:0] x,
                                                   input logic [4:0] r);
      return (x << r) | (x >> (6'd32 - {1'b0, r}));
   endfunction

endpackage

// File: sv/ipv4m_ram.sv
module ipv4m_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ipv4m_hash.sv
module ipv4m_hash import ipv4m_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEFAULT,
   localparam int BW = $clog2(BUCKETS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_WIDTH-1:0] key,
   input  logic [KEY_WIDTH-1:0] seed,
   output logic                 done,
   output logic [BW-1:0]        bucket
);

   localparam bit                 IS_POW2   = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam int                 PROD_W    = 2 * KEY_WIDTH + 1;
   localparam logic [63:0]        RECIP_NUM = 64'd1 << (KEY_WIDTH + BW);
   localparam logic [KEY_WIDTH:0] RECIP     =
      (KEY_WIDTH + 1)'((RECIP_NUM + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
   localparam logic [BW-1:0]      DIVISOR   = BW'(BUCKETS);
   localparam logic [2:0]         MIX_LAST  = 3'd6;

   typedef enum logic [1:0] {
      H_IDLE,
      H_MIX,
      H_RECIP,
      H_REDUCE
   } hstate_type;

   hstate_type           state_ff, state_in;
   logic                 done_ff, done_in;
   logic [BW-1:0]        bucket_ff, bucket_in;
   logic [KEY_WIDTH-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [KEY_WIDTH-1:0] a_mix, b_mix, c_mix;
   logic [2:0]           step_ff, step_in;
   logic [KEY_WIDTH-1:0] q_ff, q_in;
   logic [PROD_W-1:0]    prod;
   logic [BW-1:0]        r_red;

   // one step of the jhash final mix per cycle
   always_comb begin
      a_mix = a_ff;
      b_mix = b_ff;
      c_mix = c_ff;
      unique case (step_ff)
         3'd0: c_mix = (c_ff ^ b_ff) - rotl32(b_ff, 5'd14);
         3'd1: a_mix = (a_ff ^ c_ff) - rotl32(c_ff, 5'd11);
         3'd2: b_mix = (b_ff ^ a_ff) - rotl32(a_ff, 5'd25);
         3'd3: c_mix = (c_ff ^ b_ff) - rotl32(b_ff, 5'd16);
         3'd4: a_mix = (a_ff ^ c_ff) - rotl32(c_ff, 5'd4);
         3'd5: b_mix = (b_ff ^ a_ff) - rotl32(a_ff, 5'd14);
         3'd6: c_mix = (c_ff ^ b_ff) - rotl32(b_ff, 5'd24);
         default: ;
      endcase
   end

   // remainder by bucket count: quotient by reciprocal multiply, then low bits of c - q * n
   assign prod  = PROD_W'(c_ff) * PROD_W'(RECIP);
   assign r_red = c_ff[BW-1:0] - q_ff[BW-1:0] * DIVISOR;

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      bucket_in = bucket_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      step_in   = step_ff;
      q_in      = q_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               a_in     = key + HASH_INIT;
               b_in     = HASH_INIT;
               c_in     = seed;
               step_in  = 3'd0;
               state_in = H_MIX;
            end
         end
         H_MIX: begin
            a_in    = a_mix;
            b_in    = b_mix;
            c_in    = c_mix;
            step_in = step_ff + 3'd1;
            if (step_ff == MIX_LAST) begin
               if (IS_POW2) begin
                  done_in   = 1'b1;
                  bucket_in = c_mix[BW-1:0];
                  state_in  = H_IDLE;
               end else begin
                  state_in = H_RECIP;
               end
            end
         end
         H_RECIP: begin
            q_in     = KEY_WIDTH'(prod >> (KEY_WIDTH + BW));
            state_in = H_REDUCE;
         end
         H_REDUCE: begin
            done_in   = 1'b1;
            bucket_in = r_red;
            state_in  = H_IDLE;
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      step_ff   <= step_in;
      q_ff      <= q_in;
      bucket_ff <= bucket_in;
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

// File: sv/ipv4_address_set_match_unit.sv
// IPv4 address set lookup. A command is taken when start is high and busy is low; exactly one
// result beat follows on rsp_valid for a single cycle and cannot be held off, so the receiver
// must take it when it appears. Match, add and remove keep busy high from accept until their
// result: the bucket hash runs one mixing round per cycle, a non-power-of-two bucket count adds
// a reciprocal-multiply state and a reduce state for the remainder, then one bucket row holding
// all ways is read and, for an add or remove that changes it, written back. Flush and the
// clearing pass after reset sweep the bucket memory one row per cycle, with busy high for the
// whole sweep; configuration writes are taken at any time but belong only in idle periods.
module ipv4_address_set_match_unit import ipv4m_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEFAULT,
   parameter int WAYS    = WAYS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

`include "assert_macros.svh"

   localparam int BW     = $clog2(BUCKETS);
   localparam int ROW_W  = WAYS * ENTRY_WIDTH;
   localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_LOOKUP
   } state_type;

   state_type            state_ff, state_in;
   logic                 flush_ff, flush_in;
   logic [BW-1:0]        clr_addr_ff, clr_addr_in;
   mode_type             mode_ff, mode_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [BW-1:0]        bucket_ff, bucket_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 match_side_ff, match_invert_ff;
   logic [KEY_WIDTH-1:0] hash_seed_ff;

   logic                 accept;
   logic [KEY_WIDTH-1:0] req_key;
   logic                 hash_start, hash_done;
   logic [BW-1:0]        hash_bucket;

   logic                 ram_wr_en, ram_rd_en;
   logic [BW-1:0]        ram_wr_addr;
   logic [ROW_W-1:0]     ram_wr_data, ram_rd_data;

   entry_type [WAYS-1:0] rd_row, wr_row;
   logic [WAYS-1:0]      hit_oh, free_oh;
   logic                 found, has_free;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign req_key   = (req_data.mode == MODE_MATCH && match_side_ff) ?
                      req_data.dest_address : req_data.source_address;
   assign hash_start = accept && (req_data.mode != MODE_FLUSH);
   assign csr_ready = 1'b1;

   ipv4m_hash #(
      .BUCKETS (BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (req_key),
      .seed   (hash_seed_ff),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   ipv4m_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (hash_bucket),
      .rd_data (ram_rd_data)
   );

   assign rd_row = ram_rd_data;

   // first matching way and first free way of the bucket row
   always_comb begin
      found    = 1'b0;
      has_free = 1'b0;
      hit_oh   = '0;
      free_oh  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row[w].valid && rd_row[w].addr == key_ff && !found) begin
            hit_oh[w] = 1'b1;
            found     = 1'b1;
         end
         if (!rd_row[w].valid && !has_free) begin
            free_oh[w] = 1'b1;
            has_free   = 1'b1;
         end
      end
   end

   always_comb begin
      wr_row = rd_row;
      for (int w = 0; w < WAYS; w++) begin
         if (mode_ff == MODE_ADD && free_oh[w]) begin
            wr_row[w].valid = 1'b1;
            wr_row[w].addr  = key_ff;
         end
         if (mode_ff == MODE_REMOVE && hit_oh[w]) begin
            wr_row[w] = '0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      flush_in     = flush_ff;
      clr_addr_in  = clr_addr_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      bucket_in    = bucket_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = bucket_ff;
      ram_wr_data  = wr_row;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + BW'(1);
            if (clr_addr_ff == LAST_ROW) begin
               state_in     = ST_IDLE;
               flush_in     = 1'b0;
               rsp_valid_in = flush_ff;
               rsp_in       = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               key_in  = req_key;
               if (req_data.mode == MODE_FLUSH) begin
                  state_in    = ST_CLEAR;
                  flush_in    = 1'b1;
                  clr_addr_in = '0;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               ram_rd_en = 1'b1;
               bucket_in = hash_bucket;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            unique case (mode_ff)
               MODE_MATCH: rsp_in.hit = found ^ match_invert_ff;
               MODE_ADD: begin
                  rsp_in.hit    = found;
                  rsp_in.status = !found && !has_free;
                  ram_wr_en     = !found && has_free;
               end
               MODE_REMOVE: begin
                  rsp_in.hit = found;
                  ram_wr_en  = found;
               end
               MODE_FLUSH: ;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      bucket_ff <= bucket_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         flush_ff     <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_ff     <= flush_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_side_ff   <= 1'b0;
         match_invert_ff <= 1'b0;
         hash_seed_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MATCH_SIDE:   match_side_ff   <= csr_data[0];
            CSR_MATCH_INVERT: match_invert_ff <= csr_data[0];
            CSR_HASH_SEED:    hash_seed_ff    <= csr_data[KEY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IPV4M_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
   `IPV4M_ASSERT_NEXT(a_single_beat, rsp_valid, !rsp_valid, "result beat longer than one cycle")
   `IPV4M_ASSERT_IMP(a_full_no_hit, rsp_valid && rsp_data.status, !rsp_data.hit, "full with hit")
   `IPV4M_ASSERT_IMP(a_write_owner, ram_wr_en, state_ff == ST_CLEAR || state_ff == ST_LOOKUP, "stray write")
   `IPV4M_ASSERT_IMP(a_read_in_hash, ram_rd_en, state_ff == ST_HASH && hash_done, "stray read")

endmodule
